>>> design/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg
// Shared types and constants of the coalesced hash insert engine: field
// widths, slot entry kinds and the states of the insert sequencer.
// ----------------------------------------------------------------------------
package chi_pkg;

	localparam int ID_W       = 32;
	localparam int SUM_W      = ID_W + 1;
	localparam int SIZE_CFG_W = 11;
	localparam int SLOT_W     = 10;
	localparam int COUNT_W    = 32;
	localparam int STEP_W     = 6;

	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = SIZE_CFG_W'(1024);
	localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_END   = 2'd1,
		KIND_LINK  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HOME,
		ST_WALK,
		ST_SCAN,
		ST_LINK,
		ST_PLACE,
		ST_DONE
	} state_t;

endpackage

>>> design/coalesced_hash_insert.sv
// ----------------------------------------------------------------------------
// coalesced_hash_insert
// Insert engine for a coalesced hash table without a cellar.
// ----------------------------------------------------------------------------
// After reset the engine sweeps all TABLE_DEPTH slots of the link memory to
// empty, one slot per cycle, and takes no insert until the sweep is done; the
// table size register can be written at any time the engine is idle. Inserts
// are handled one at a time. An insert is transferred, the serial remainder
// unit reduces its key sum to the home slot, the home slot is read, links
// are followed along the chain, slots are tried in the downward scan, up to
// 2 writes are made (none when the table is full) and the result is
// presented once the previous result no longer waits on out_stall. The
// chain walk and the scan each read the single link memory port once per
// cycle, so a collision adds the link write plus one read per link followed
// and per slot tried in the scan.
// ----------------------------------------------------------------------------
module coalesced_hash_insert
	import chi_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [SIZE_CFG_W-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ID_W-1:0]       movie_id,
	input  logic [ID_W-1:0]       user_id,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SLOT_W-1:0]     slot,
	output logic                  table_full,
	output logic [COUNT_W-1:0]    total_collisions
);

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DW  = $clog2(TABLE_DEPTH + 1);
	localparam int SW  = (DW > SIZE_CFG_W) ? DW : SIZE_CFG_W;
	localparam int XW  = (AW > SLOT_W) ? AW : SLOT_W;

	localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);
	localparam logic [SW-1:0] SIZE_MIN = SW'(2);
	localparam logic [SW-1:0] SIZE_MAX = SW'(TABLE_DEPTH);

	function automatic logic [COUNT_W-1:0] count_one(input logic [COUNT_W-1:0] c);
		count_one = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
	endfunction

	state_t                state_q, state_next;
	logic [SIZE_CFG_W-1:0] table_size_q;
	logic [AW-1:0]         clr_q;
	logic [COUNT_W-1:0]    coll_q;
	logic                  full_q;
	logic                  out_valid_q;
	logic                  out_load;

	logic [2*ID_W-1:0]     pair_q;
	logic [SW-1:0]         size_q;
	logic [AW-1:0]         tail_q;
	logic [AW-1:0]         scan_q;
	logic [AW-1:0]         slot_q;
	logic [SLOT_W-1:0]     slot_out_q;
	logic                  full_out_q;
	logic [COUNT_W-1:0]    coll_out_q;

	logic [SW-1:0]         size_cfg;
	logic [SW-1:0]         size_use;
	logic [SW-1:0]         size_m1;
	logic [AW-1:0]         scan_top;
	logic [XW-1:0]         slot_wide;

	logic                  hash_start;
	logic                  hash_busy;
	logic [AW-1:0]         hash_rem;
	logic [SUM_W-1:0]      key_sum;

	logic                  mem_wr_en;
	logic [AW-1:0]         mem_wr_addr;
	kind_t                 mem_wr_kind;
	logic [AW-1:0]         mem_wr_next;
	logic                  mem_pair_en;
	logic [AW-1:0]         mem_rd_addr;
	kind_t                 mem_rd_kind;
	logic [AW-1:0]         mem_rd_next;

	// Size in use is the configured size clamped to the range of the table.
	always_comb begin
		size_cfg = SW'(table_size_q);
		if (size_cfg < SIZE_MIN) begin
			size_use = SIZE_MIN;
		end else if (size_cfg > SIZE_MAX) begin
			size_use = SIZE_MAX;
		end else begin
			size_use = size_cfg;
		end
	end

	assign size_m1   = size_q - SW'(1);
	assign scan_top  = size_m1[AW-1:0];
	assign key_sum   = {1'b0, movie_id} + {1'b0, user_id};
	assign slot_wide = XW'(slot_q);

	chi_hash_mod #(
		.SW(SW),
		.AW(AW)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.dividend(key_sum),
		.divisor (size_use),
		.busy    (hash_busy),
		.rem     (hash_rem)
	);

	chi_slot_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_kind   (mem_wr_kind),
		.wr_next   (mem_wr_next),
		.wr_pair_en(mem_pair_en),
		.wr_pair   (pair_q),
		.rd_addr   (mem_rd_addr),
		.rd_kind   (mem_rd_kind),
		.rd_next   (mem_rd_next)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_HASH;
				end
			end
			ST_HASH: begin
				if (!hash_busy) begin
					state_next = ST_HOME;
				end
			end
			ST_HOME: begin
				case (mem_rd_kind)
					KIND_EMPTY: state_next = ST_PLACE;
					KIND_LINK:  state_next = ST_WALK;
					default:    state_next = ST_SCAN;
				endcase
			end
			ST_WALK: begin
				if (mem_rd_kind != KIND_LINK) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (mem_rd_kind == KIND_EMPTY) begin
					state_next = ST_LINK;
				end else if (scan_q == '0) begin
					state_next = ST_DONE;
				end
			end
			ST_LINK:  state_next = ST_PLACE;
			ST_PLACE: state_next = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		hash_start  = 1'b0;
		out_load    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = tail_q;
		mem_wr_kind = KIND_EMPTY;
		mem_wr_next = '0;
		mem_pair_en = 1'b0;
		mem_rd_addr = tail_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				hash_start = in_valid;
			end
			ST_HASH: begin
				mem_rd_addr = hash_rem;
			end
			ST_HOME, ST_WALK: begin
				mem_rd_addr = (mem_rd_kind == KIND_LINK) ? mem_rd_next : scan_top;
			end
			ST_SCAN: begin
				mem_rd_addr = scan_q - AW'(1);
			end
			ST_LINK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = tail_q;
				mem_wr_kind = KIND_LINK;
				mem_wr_next = slot_q;
			end
			ST_PLACE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q;
				mem_wr_kind = KIND_END;
				mem_pair_en = 1'b1;
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			table_size_q <= SIZE_RESET;
			clr_q        <= '0;
			coll_q       <= '0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE && in_valid) begin
				full_q <= 1'b0;
			end
			if ((state_q == ST_HOME && mem_rd_kind != KIND_EMPTY) ||
			    (state_q == ST_WALK && mem_rd_kind == KIND_LINK) ||
			    (state_q == ST_SCAN && mem_rd_kind != KIND_EMPTY)) begin
				coll_q <= count_one(coll_q);
			end
			if (state_q == ST_SCAN && mem_rd_kind != KIND_EMPTY && scan_q == '0) begin
				full_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pair_q <= {movie_id, user_id};
					size_q <= size_use;
				end
			end
			ST_HASH: begin
				tail_q <= hash_rem;
			end
			ST_HOME, ST_WALK: begin
				if (state_q == ST_HOME && mem_rd_kind == KIND_EMPTY) begin
					slot_q <= tail_q;
				end else if (mem_rd_kind == KIND_LINK) begin
					tail_q <= mem_rd_next;
				end else begin
					scan_q <= scan_top;
				end
			end
			ST_SCAN: begin
				if (mem_rd_kind == KIND_EMPTY) begin
					slot_q <= scan_q;
				end else begin
					scan_q <= scan_q - AW'(1);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					slot_out_q <= full_q ? '0 : slot_wide[SLOT_W-1:0];
					full_out_q <= full_q;
					coll_out_q <= coll_q;
				end
			end
			default: begin
				slot_out_q <= slot_out_q;
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign slot             = slot_out_q;
	assign table_full       = full_out_q;
	assign total_collisions = coll_out_q;

endmodule

>>> design/chi_hash_mod.sv
// ----------------------------------------------------------------------------
// chi_hash_mod
// Serial remainder unit for the home slot: reduces the 33-bit key sum modulo
// the table size, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chi_hash_mod
	import chi_pkg::*;
#(
	parameter int SW = SIZE_CFG_W,
	parameter int AW = SLOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [SW-1:0]    divisor,
	output logic             busy,
	output logic [AW-1:0]    rem
);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  div_q;
	logic [SW-1:0]     divisor_q;
	logic [SW-1:0]     rem_q;
	logic [SW:0]       trial;
	logic [SW-1:0]     rem_next;

	always_comb begin
		trial = {rem_q, div_q[SUM_W-1]};
		if (trial >= {1'b0, divisor_q}) begin
			rem_next = SW'(trial - {1'b0, divisor_q});
		end else begin
			rem_next = trial[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q     <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[SUM_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q[AW-1:0];

endmodule

>>> design/chi_slot_mem.sv
// ----------------------------------------------------------------------------
// chi_slot_mem
// Slot storage: the link memory (entry kind and next slot) with one write
// port and one registered read port, and the write-only pair memory.
// ----------------------------------------------------------------------------
module chi_slot_mem
	import chi_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW    = SLOT_W
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  kind_t             wr_kind,
	input  logic [AW-1:0]     wr_next,
	input  logic              wr_pair_en,
	input  logic [2*ID_W-1:0] wr_pair,
	input  logic [AW-1:0]     rd_addr,
	output kind_t             rd_kind,
	output logic [AW-1:0]     rd_next
);

	localparam int LW = AW + 2;

	logic [LW-1:0]     link_mem [DEPTH];
	logic [2*ID_W-1:0] pair_mem [DEPTH];
	logic [LW-1:0]     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= {wr_kind, wr_next};
		end
		rd_data_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_pair_en) begin
			pair_mem[wr_addr] <= wr_pair;
		end
	end

	assign rd_kind = kind_t'(rd_data_q[LW-1:AW]);
	assign rd_next = rd_data_q[AW-1:0];

endmodule

>>> design/chi_checker.sv
// ----------------------------------------------------------------------------
// chi_checker
// Port-level checks of the insert engine: one insert at a time, stable
// results under stall, a consistent full result and a running count that
// never falls.
// ----------------------------------------------------------------------------
module chi_checker
	import chi_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [SLOT_W-1:0]     slot,
	input logic                  table_full,
	input logic [COUNT_W-1:0]    total_collisions
);

	logic [COUNT_W-1:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_count_q <= total_collisions;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input transfer taken while an insert is in progress");

	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (slot == '0))
		else $error("full result carries a nonzero slot");

	a_count_rises: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> (total_collisions >= last_count_q))
		else $error("collision count fell between transfers");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(slot) &&
		$stable(table_full) && $stable(total_collisions)))
		else $error("stalled result changed");

endmodule

bind coalesced_hash_insert chi_checker u_chi_checker (.*);
